>>> rtl/core/hlg_pkg.sv
// Huber loss / gradient / Hessian block: shared types and constants.
// No dependencies; every other file of the block except hlg_fifo imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hlg_pkg;

    localparam int THR_W  = 15;
    localparam int GRAD_W = 17;
    localparam int HESS_W = 2;
    localparam int LOSS_W = 48;

    typedef logic [THR_W-1:0] thr_t;

    localparam thr_t THR_RESET = 15'd256;   // 1.0 in Q7.8

    // Hessian diagonal codes
    localparam logic [HESS_W-1:0] HESS_IN  = 2'd2;
    localparam logic [HESS_W-1:0] HESS_OUT = 2'd0;

    // Per-word result of classification, carried through the queue
    typedef struct packed {
        logic signed [GRAD_W-1:0] grad;
        logic [HESS_W-1:0]        hess;
        logic                     last;
    } cls_t;

endpackage

`default_nettype wire

>>> rtl/core/hlg_ifs.sv
// Valid/ready channel interfaces for the residual input and the result output.
// Depends on hlg_pkg for the fixed result field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hlg_elem_if #(
    parameter int RESIDUAL_WIDTH = 16
);
    logic                             valid;
    logic                             ready;
    logic signed [RESIDUAL_WIDTH-1:0] residual;
    logic                             last_element;

    modport source (output valid, output residual, output last_element, input ready);
    modport sink   (input valid, input residual, input last_element, output ready);
endinterface

interface hlg_result_if;
    import hlg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] gradient_value;
    logic [HESS_W-1:0]        hessian_diagonal;
    logic [LOSS_W-1:0]        loss_total;
    logic                     loss_saturated;
    logic                     end_of_vector;

    modport source (
        output valid, output gradient_value, output hessian_diagonal,
        output loss_total, output loss_saturated, output end_of_vector,
        input ready
    );
    modport sink (
        input valid, input gradient_value, input hessian_diagonal,
        input loss_total, input loss_saturated, input end_of_vector,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/hlg_front.sv
// Front end: accepts residual words, classifies against the threshold,
// forms gradient, Hessian entry and multiplier operands. Uses hlg_pkg, hlg_ifs.
`timescale 1ns / 1ps
`default_nettype none

module hlg_front #(
    parameter int RESIDUAL_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hlg_pkg::thr_t         threshold,
    hlg_elem_if.sink                   element,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output hlg_pkg::cls_t              out_cls,
    output logic [((RESIDUAL_WIDTH > hlg_pkg::THR_W) ? RESIDUAL_WIDTH : hlg_pkg::THR_W)-1:0]
                                       out_op_a,
    output logic [((RESIDUAL_WIDTH > hlg_pkg::THR_W) ? RESIDUAL_WIDTH : hlg_pkg::THR_W):0]
                                       out_op_b
);
    import hlg_pkg::*;

    localparam int RW    = RESIDUAL_WIDTH;
    localparam int OPA_W = (RW > THR_W) ? RW : THR_W;
    localparam int OPB_W = OPA_W + 1;
    localparam int GX_W  = OPA_W + 2;

    logic signed [RW-1:0]   e;
    logic [RW-1:0]          mag;
    logic [OPA_W-1:0]       mag_x;
    logic [OPA_W-1:0]       thr_x;
    logic                   in_band;
    logic signed [GX_W-1:0] e_x;
    logic signed [GX_W-1:0] d2;
    logic signed [GX_W-1:0] grad_x;
    logic                   f_valid_reg;
    logic                   f_valid_next;
    logic                   load;
    cls_t                   cls_reg;
    cls_t                   cls_next;
    logic [OPA_W-1:0]       op_a_reg;
    logic [OPA_W-1:0]       op_a_next;
    logic [OPB_W-1:0]       op_b_reg;
    logic [OPB_W-1:0]       op_b_next;

    assign e       = element.residual;
    assign mag     = e[RW-1] ? $unsigned(-e) : $unsigned(e);
    assign mag_x   = OPA_W'(mag);
    assign thr_x   = OPA_W'(threshold);
    // |e| equal to delta falls in the linear region
    assign in_band = mag_x < thr_x;
    assign e_x     = GX_W'(e);
    assign d2      = $signed({1'b0, thr_x, 1'b0});

    always_comb
    begin
        if (in_band)
        begin
            grad_x = e_x <<< 1;
        end
        else if (e == '0)
        begin
            grad_x = '0;
        end
        else if (e[RW-1])
        begin
            grad_x = -d2;
        end
        else
        begin
            grad_x = d2;
        end
        cls_next.grad = grad_x[GRAD_W-1:0];
        cls_next.hess = in_band ? HESS_IN : HESS_OUT;
        cls_next.last = element.last_element;
        // inside: mag*mag, outside: delta*(2|e| - delta)
        op_a_next = in_band ? mag_x : thr_x;
        op_b_next = in_band ? OPB_W'(mag_x) : ({mag_x, 1'b0} - OPB_W'(thr_x));
    end

    assign element.ready = !f_valid_reg || out_ready;
    assign load          = element.valid && element.ready;
    assign f_valid_next  = element.ready ? element.valid : f_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cls_reg  <= cls_next;
            op_a_reg <= op_a_next;
            op_b_reg <= op_b_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_cls   = cls_reg;
    assign out_op_a  = op_a_reg;
    assign out_op_b  = op_b_reg;

`ifndef SYNTHESIS
    // a staged word is never dropped while the queue is full
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg && !out_ready |=> f_valid_reg)
        else $error("front word lost under stall");
    // gradient is always an even multiple of the LSB
    a_grad_even: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg |-> !cls_reg.grad[0])
        else $error("odd gradient");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hlg_fifo.sv
// Short word queue that decouples the front end from the back end.
// Generic width and depth; uses no package.
`timescale 1ns / 1ps
`default_nettype none

module hlg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign in_ready  = cnt_reg != CNT_W'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy past depth");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hlg_back.sv
// Back end: loss term multiply, saturating running sum, output register.
// Uses hlg_pkg and hlg_result_if from hlg_ifs.
`timescale 1ns / 1ps
`default_nettype none

module hlg_back #(
    parameter int OPA_W     = 16,
    parameter int SUM_WIDTH = 48
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hlg_pkg::cls_t      in_cls,
    input  wire logic [OPA_W-1:0]   in_op_a,
    input  wire logic [OPA_W:0]     in_op_b,
    hlg_result_if.source            result
);
    import hlg_pkg::*;

    localparam int OPB_W  = OPA_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ADD_W  = ((SUM_WIDTH > PROD_W) ? SUM_WIDTH : PROD_W) + 1;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

    logic                  m_valid_reg;
    logic                  m_valid_next;
    cls_t                  m_cls_reg;
    logic [PROD_W-1:0]     m_prod_reg;
    logic [PROD_W-1:0]     m_prod_next;
    logic                  adv_m;
    logic                  adv_o;
    logic                  ld_m;
    logic                  ld_o;
    logic                  o_valid_reg;
    logic                  o_valid_next;
    cls_t                  o_cls_reg;
    logic [LOSS_W-1:0]     o_loss_reg;
    logic                  o_sat_reg;
    logic [SUM_WIDTH-1:0]  acc_reg;
    logic [SUM_WIDTH-1:0]  acc_next;
    logic                  sat_reg;
    logic                  sat_next;
    logic [ADD_W-1:0]      sum;
    logic                  ovf;
    logic [SUM_WIDTH-1:0]  new_acc;
    logic                  new_sat;

    assign adv_o    = !o_valid_reg || result.ready;
    assign adv_m    = !m_valid_reg || adv_o;
    assign in_ready = adv_m;
    assign ld_m     = in_valid && adv_m;
    assign ld_o     = m_valid_reg && adv_o;

    assign m_prod_next  = PROD_W'(in_op_a) * PROD_W'(in_op_b);
    assign m_valid_next = adv_m ? in_valid : m_valid_reg;
    assign o_valid_next = adv_o ? m_valid_reg : o_valid_reg;

    always_comb
    begin
        sum     = ADD_W'(acc_reg) + ADD_W'(m_prod_reg);
        ovf     = |sum[ADD_W-1:SUM_WIDTH];
        new_acc = ovf ? SUM_MAX : sum[SUM_WIDTH-1:0];
        new_sat = sat_reg || ovf;
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (ld_o)
        begin
            // the word marked last shows the final sum, then the sum restarts
            acc_next = m_cls_reg.last ? '0 : new_acc;
            sat_next = m_cls_reg.last ? 1'b0 : new_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            o_valid_reg <= o_valid_next;
            acc_reg     <= acc_next;
            sat_reg     <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_m)
        begin
            m_cls_reg  <= in_cls;
            m_prod_reg <= m_prod_next;
        end
        if (ld_o)
        begin
            o_cls_reg  <= m_cls_reg;
            o_loss_reg <= LOSS_W'(new_acc);
            o_sat_reg  <= new_sat;
        end
    end

    assign result.valid            = o_valid_reg;
    assign result.gradient_value   = o_cls_reg.grad;
    assign result.hessian_diagonal = o_cls_reg.hess;
    assign result.loss_total       = o_loss_reg;
    assign result.loss_saturated   = o_sat_reg;
    assign result.end_of_vector    = o_cls_reg.last;

`ifndef SYNTHESIS
    a_sat_pinned: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_sat_reg |-> o_loss_reg == LOSS_W'(SUM_MAX))
        else $error("saturation flag without pinned sum");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ld_o && m_cls_reg.last |=> acc_reg == '0 && !sat_reg)
        else $error("sum not cleared after end of vector");
`endif

endmodule

`default_nettype wire

>>> rtl/core/huber_loss_gradient_hessian.sv
// Huber loss gradient/Hessian block: one result word per residual word.
// A result word passes the front register, the queue, the multiply register
// and the output register. Throughput: 1 word per cycle while result.ready
// holds, with the accumulate in the back end updated once per accepted word.
// Reset: threshold 256 (1.0), running sum and saturation flag zero, queue empty.
// Depends on hlg_pkg, hlg_ifs, hlg_front, hlg_fifo, hlg_back.
`timescale 1ns / 1ps
`default_nettype none

module huber_loss_gradient_hessian #(
    parameter int RESIDUAL_WIDTH = 16,
    parameter int SUM_WIDTH      = 48,
    parameter int QUEUE_DEPTH    = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire hlg_pkg::thr_t cfg_wr_data,
    hlg_elem_if.sink           element,
    hlg_result_if.source       result
);
    import hlg_pkg::*;

    localparam int OPA_W  = (RESIDUAL_WIDTH > THR_W) ? RESIDUAL_WIDTH : THR_W;
    localparam int OPB_W  = OPA_W + 1;
    localparam int WORD_W = $bits(cls_t) + OPA_W + OPB_W;

    thr_t              thr_reg;
    thr_t              thr_next;
    logic              f_valid;
    logic              f_ready;
    cls_t              f_cls;
    logic [OPA_W-1:0]  f_op_a;
    logic [OPB_W-1:0]  f_op_b;
    logic              q_valid;
    logic              q_ready;
    logic [WORD_W-1:0] q_data;
    cls_t              q_cls;
    logic [OPA_W-1:0]  q_op_a;
    logic [OPB_W-1:0]  q_op_b;

    assign thr_next = cfg_wr_en ? cfg_wr_data : thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    hlg_front #(
        .RESIDUAL_WIDTH (RESIDUAL_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thr_reg),
        .element   (element),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_cls   (f_cls),
        .out_op_a  (f_op_a),
        .out_op_b  (f_op_b)
    );

    hlg_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_cls, f_op_a, f_op_b}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign {q_cls, q_op_a, q_op_b} = q_data;

    hlg_back #(
        .OPA_W     (OPA_W),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_cls   (q_cls),
        .in_op_a  (q_op_a),
        .in_op_b  (q_op_b),
        .result   (result)
    );

endmodule

`default_nettype wire

>>> dv/hlg_loss_checker.sv
// Scoreboard for the Huber loss block: watches the residual and result channels,
// predicts gradient, Hessian entry and running loss, and counts mismatches.
// Depends on hlg_pkg for the threshold type and the result field widths.
`timescale 1ns / 1ps

module hlg_loss_checker #(
    parameter int RESIDUAL_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire hlg_pkg::thr_t                        cfg_wr_data,
    input  wire logic                                 elem_valid,
    input  wire logic                                 elem_ready,
    input  wire logic signed [RESIDUAL_WIDTH-1:0]     elem_residual,
    input  wire logic                                 elem_last,
    input  wire logic                                 res_valid,
    input  wire logic                                 res_ready,
    input  wire logic signed [hlg_pkg::GRAD_W-1:0]    res_gradient,
    input  wire logic [hlg_pkg::HESS_W-1:0]           res_hessian,
    input  wire logic [hlg_pkg::LOSS_W-1:0]           res_loss,
    input  wire logic                                 res_saturated,
    input  wire logic                                 res_end,
    output int                                        words_due,
    output int                                        fail_count
);
    import hlg_pkg::*;

    localparam longint LOSS_MAX = (longint'(1) <<< LOSS_W) - 1;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad;
        logic [HESS_W-1:0]        hess;
        logic [LOSS_W-1:0]        loss;
        logic                     sat;
        logic                     eov;
    } loss_word_t;

    loss_word_t results_due[$];
    thr_t       huber_delta;
    longint     running_loss;
    logic       loss_clipped;

    task automatic predict_loss_word(input logic signed [RESIDUAL_WIDTH-1:0] residual,
                                     input logic last);
        longint     e;
        longint     mag;
        longint     d;
        longint     grad;
        longint     term;
        logic       in_band;
        loss_word_t w;
        e = residual;
        d = longint'(huber_delta);
        mag = (e < 0) ? -e : e;
        in_band = mag < d;
        if (in_band)
        begin
            grad = 2 * e;
            term = mag * mag;
        end
        else
        begin
            // zero residual outside the band (only at d = 0) has zero slope
            grad = (e > 0) ? 2 * d : (e < 0) ? -2 * d : 0;
            term = d * (2 * mag - d);
        end
        if (running_loss > LOSS_MAX - term)
        begin
            running_loss = LOSS_MAX;
            loss_clipped = 1'b1;
        end
        else
        begin
            running_loss = running_loss + term;
        end
        w.grad = grad[GRAD_W-1:0];
        w.hess = in_band ? HESS_IN : HESS_OUT;
        w.loss = running_loss[LOSS_W-1:0];
        w.sat  = loss_clipped;
        w.eov  = last;
        results_due.push_back(w);
        if (last)
        begin
            running_loss = 0;
            loss_clipped = 1'b0;
        end
    endtask

    task automatic check_loss_word();
        loss_word_t got;
        loss_word_t want;
        got.grad = res_gradient;
        got.hess = res_hessian;
        got.loss = res_loss;
        got.sat  = res_saturated;
        got.eov  = res_end;
        if (results_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected result word: grad %0d hess %0d loss %0d",
                         $realtime, got.grad, got.hess, got.loss,
                         " sat %0b eov %0b", got.sat, got.eov);
        end
        else
        begin
            want = results_due.pop_front();
            if (got.grad !== want.grad || got.hess !== want.hess || got.loss !== want.loss
                || got.sat !== want.sat || got.eov !== want.eov)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: mismatch (exp/got): grad %0d/%0d hess %0d/%0d",
                             $realtime, want.grad, got.grad, want.hess, got.hess,
                             " loss %0d/%0d sat %0b/%0b eov %0b/%0b",
                             want.loss, got.loss, want.sat, got.sat, want.eov, got.eov);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            huber_delta = THR_RESET;
            running_loss = 0;
            loss_clipped = 1'b0;
            results_due.delete();
            words_due = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
                huber_delta = cfg_wr_data;
            // retire first so a word accepted on this edge never meets its own result
            if (res_valid && res_ready)
                check_loss_word();
            if (elem_valid && elem_ready)
                predict_loss_word(elem_residual, elem_last);
            words_due = results_due.size();
        end
    end

endmodule

>>> dv/huber_loss_gradient_hessian_test.sv
// Testbench top for huber_loss_gradient_hessian: drives residual words and the
// threshold register, paces the result side; checking is in hlg_loss_checker.
// Depends on hlg_pkg, hlg_ifs, the block and hlg_loss_checker.
`timescale 1ns / 1ps

module huber_loss_gradient_hessian_test;
    import hlg_pkg::*;

    localparam int LIMIT           = 200_000;
    localparam int LONG_WORDS      = 60;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic signed [15:0] RES_MIN = 16'sh8000;
    localparam logic signed [15:0] RES_MAX = 16'sh7FFF;
    localparam thr_t THR_MAX = 15'h7FFF;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    thr_t cfg_wr_data;
    logic hold_off_req;
    logic rx_stalls_on;
    int   words_due;
    int   fail_count;
    int   cycle_count;

    hlg_elem_if #(.RESIDUAL_WIDTH(16)) element_ch ();
    hlg_result_if result_ch ();

    huber_loss_gradient_hessian uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .element     (element_ch),
        .result      (result_ch)
    );

    hlg_loss_checker #(.RESIDUAL_WIDTH(16)) loss_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .elem_valid    (element_ch.valid),
        .elem_ready    (element_ch.ready),
        .elem_residual (element_ch.residual),
        .elem_last     (element_ch.last_element),
        .res_valid     (result_ch.valid),
        .res_ready     (result_ch.ready),
        .res_gradient  (result_ch.gradient_value),
        .res_hessian   (result_ch.hessian_diagonal),
        .res_loss      (result_ch.loss_total),
        .res_saturated (result_ch.loss_saturated),
        .res_end       (result_ch.end_of_vector),
        .words_due     (words_due),
        .fail_count    (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[huber_loss_gradient_hessian] ERROR");
        $finish;
    end

    // result side: random ready pattern, constant ready with stalls off, or a long hold-off on request
    initial
    begin : result_sink
        int   run_left;
        logic rx_on;
        result_ch.ready = 1'b0;
        run_left = 0;
        rx_on = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else if (!rx_stalls_on)
            begin
                result_ch.ready <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    rx_on = !rx_on;
                    run_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                run_left--;
                result_ch.ready <= rx_on;
            end
        end
    end

    task automatic send_word(input logic signed [15:0] r, input logic last);
        @(negedge clk);
        element_ch.valid        <= 1'b1;
        element_ch.residual     <= r;
        element_ch.last_element <= last;
        @(posedge clk);
        while (!element_ch.ready)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            element_ch.valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        element_ch.valid <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
    endtask

    task automatic write_threshold(input thr_t d);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_residual(input thr_t d);
        int          v;
        int          sel;
        logic [31:0] raw;
        sel = $urandom_range(0, 3);
        raw = $urandom;
        case (sel)
            0:       v = int'($signed(raw[15:0]));
            1:       v = int'(d) + int'($urandom_range(0, 4)) - 2;   // around the band edge
            2:       v = int'($urandom_range(0, 64)) - 32;
            default: v = int'($urandom_range(0, int'(d)));
        endcase
        if (raw[31])
            v = -v;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic run_phase(input thr_t d, input int n_words, input logic gaps_on,
                             input logic hold_off);
        int vec_left;
        int burst_left;
        int k;
        wait_drained();
        write_threshold(d);
        if (hold_off)
            hold_off_req = 1'b1;
        vec_left = 0;
        burst_left = $urandom_range(1, 20);
        for (k = 0; k < n_words; k++)
        begin
            if (vec_left == 0)
                vec_left = $urandom_range(1, 40);
            send_word(pick_residual(d), vec_left == 1 || k == n_words - 1);
            vec_left--;
            burst_left--;
            if (burst_left == 0)
            begin
                if (gaps_on)
                    idle_cycles($urandom_range(1, 6));
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = THR_RESET;
        hold_off_req = 1'b0;
        rx_stalls_on = 1'b1;
        element_ch.valid = 1'b0;
        element_ch.residual = '0;
        element_ch.last_element = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset threshold 1.0: band interior, both band edges, field extremes
        send_word(16'sd0, 1'b0);
        send_word(16'sd255, 1'b0);
        send_word(16'sd256, 1'b0);
        send_word(-16'sd256, 1'b0);
        send_word(-16'sd255, 1'b0);
        send_word(RES_MAX, 1'b0);
        send_word(RES_MIN, 1'b0);
        send_word(16'sd1, 1'b0);
        send_word(-16'sd1, 1'b1);

        // zero threshold: everything is outside, zero residual gives zero slope
        wait_drained();
        write_threshold(15'd0);
        send_word(16'sd0, 1'b0);
        send_word(16'sd5, 1'b0);
        send_word(-16'sd5, 1'b1);

        wait_drained();
        write_threshold(THR_MAX);
        send_word(RES_MAX, 1'b0);
        send_word(16'sd32766, 1'b0);
        send_word(RES_MIN, 1'b0);
        send_word(-16'sd32767, 1'b1);

        wait_drained();
        write_threshold(15'd1);
        send_word(16'sd0, 1'b0);
        send_word(16'sd1, 1'b1);

        // one long vector of maximal terms at full rate, then a one-word vector
        wait_drained();
        rx_stalls_on = 1'b0;
        write_threshold(THR_MAX);
        repeat (LONG_WORDS) send_word(RES_MIN, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(16'sd100, 1'b1);
        send_word(16'sd5, 1'b1);
        wait_drained();
        rx_stalls_on = 1'b1;

        run_phase(thr_t'($urandom_range(0, 32767)), 300, 1'b1, 1'b0);
        run_phase(thr_t'($urandom_range(0, 16)), 250, 1'b1, 1'b1);
        run_phase(THR_RESET, 250, 1'b0, 1'b0);
        run_phase(THR_MAX, 200, 1'b1, 1'b0);
        run_phase(15'd0, 150, 1'b1, 1'b0);
        run_phase(thr_t'($urandom_range(0, 32767)), 350, 1'b1, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && words_due == 0)
            $display("[huber_loss_gradient_hessian] OK");
        else
            $display("[huber_loss_gradient_hessian] ERROR");
        $finish;
    end

endmodule
